[design/ptr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptr_pkg;

    typedef enum logic [1:0] {
        FUNC_CHECK        = 2'd0,
        FUNC_UPDATE       = 2'd1,
        FUNC_COUNT_METRIC = 2'd2,
        FUNC_COUNT_ONLY   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MATCH_SAME   = 2'd0,
        MATCH_DIFF   = 2'd1,
        MATCH_ABSENT = 2'd2
    } t_match;

    typedef struct packed {
        t_func       func;
        logic [15:0] node_id;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [47:0] mac;
        logic [15:0] rank_in;
        logic [31:0] metric_in;
        logic [31:0] precount;
        logic [15:0] num_dio;
        logic [31:0] extra_cost;
    } t_in_item;

    typedef struct packed {
        t_match      match_status;
        logic        dropped;
        logic [63:0] best_addr_hi;
        logic [63:0] best_addr_lo;
        logic [47:0] best_mac;
        logic [15:0] best_rank_plus_one;
        logic [15:0] best_node;
        logic [31:0] metric_out;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
        logic sort_step;
        logic div_step;
        logic write_metric;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  match;
        logic  at_end;
        logic  sort_done;
        logic  div_done;
    } t_status;

endpackage
`default_nettype wire

[design/ptr_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ptr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/parent_table_ranker.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  payload               handshake
// i_item   in         ptr_pkg::t_in_item    valid/ready
// o_res    out        ptr_pkg::t_out_item   valid/ready
//
// One transaction at a time: a load, a scan until a match or the table end, an apply,
// then odd-even sort passes (update, count only) or restoring divider steps and a
// metric write (count and metric), then an emit. Scan length, sort passes and
// divider steps set how long a transaction takes.
// Synchronous active-low reset empties the table; entry contents are not cleared.
// The result register holds while o_res.ready is low; the next transaction is
// accepted and processed, then holds at emit until the register frees.
module parent_table_ranker #(
    parameter int PARENT_SLOTS     = 16,
    parameter int METRIC_FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ptr_stream_if.sink   i_item,
    ptr_stream_if.source o_res
);
    ptr_pkg::t_cmd    cmd;
    ptr_pkg::t_status status;

    ptr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ptr_dp #(
        .SLOTS (PARENT_SLOTS),
        .FRAC  (METRIC_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_item.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_data   (o_res.data)
    );
endmodule
`default_nettype wire

[design/ptr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptr_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    input  ptr_pkg::t_status i_status,
    output ptr_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_SORT, S_DIV, S_WRITE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   emit_ok;

    assign emit_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.match || i_status.at_end) n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                unique case (i_status.func)
                    ptr_pkg::FUNC_CHECK:        n_state = S_DONE;
                    ptr_pkg::FUNC_COUNT_METRIC: n_state = S_DIV;
                    default:                    n_state = S_SORT;
                endcase
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_status.sort_done) n_state = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_metric = 1'b1;
                n_state            = S_DONE;
            end
            S_DONE: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[design/ptr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptr_dp #(
    parameter int SLOTS = 16,
    parameter int FRAC  = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ptr_pkg::t_in_item    i_data,
    input  ptr_pkg::t_cmd        i_cmd,
    output ptr_pkg::t_status     o_status,
    output ptr_pkg::t_out_item   o_data
);
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OCC_W  = $clog2(SLOTS + 1);
    localparam int DW     = 16 + FRAC;
    localparam int DC_W   = $clog2(DW + 1);
    localparam int SUM_W  = ((DW > 32) ? DW : 32) + 2;

    typedef struct packed {
        logic [15:0] node;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [47:0] mac;
        logic [15:0] rank;
        logic [31:0] metric;
        logic [15:0] count;
    } t_entry;

    function automatic logic [15:0] bump(input logic [15:0] c);
        bump = (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic logic less(input t_entry a, input t_entry b);
        less = (a.metric != b.metric) ? (a.metric < b.metric) : (a.rank < b.rank);
    endfunction

    ptr_pkg::t_in_item  r_in;
    ptr_pkg::t_out_item r_res;
    ptr_pkg::t_out_item n_res;
    ptr_pkg::t_match    r_match;
    t_entry             r_tab [SLOTS];
    t_entry             n_tab [SLOTS];
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   r_idx;
    logic [OCC_W-1:0]   r_pass;
    logic               r_kv;
    logic               r_dropped;
    logic [15:0]        r_cnt;
    logic [DW-1:0]      r_dvd;
    logic [15:0]        r_rem;
    logic [DC_W-1:0]    r_dcnt;
    logic [31:0]        r_metric;

    t_entry             cur;
    t_entry             fresh;
    logic               key_hit;
    logic               full;
    logic [16:0]        rem_sh;
    logic               ge;
    logic [SUM_W-1:0]   sum;
    logic [31:0]        sat_m;

    assign cur     = r_tab[r_idx[IDX_W-1:0]];
    assign full    = (r_occ == OCC_W'(SLOTS));
    assign key_hit = (r_idx < r_occ) &&
                     ((r_in.func == ptr_pkg::FUNC_CHECK) ?
                      (cur.addr_hi == r_in.addr_hi && cur.addr_lo == r_in.addr_lo) :
                      (cur.node == r_in.node_id));
    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_cnt};
    assign sum     = SUM_W'(r_dvd) + SUM_W'(r_in.precount) + SUM_W'(r_in.extra_cost);
    assign sat_m   = (|sum[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];

    assign o_status.func      = r_in.func;
    assign o_status.match     = key_hit;
    assign o_status.at_end    = ({1'b0, r_idx} + (OCC_W + 1)'(1)) >= {1'b0, r_occ};
    assign o_status.sort_done = (r_pass == OCC_W'(SLOTS - 1));
    assign o_status.div_done  = (r_dcnt == DC_W'(DW - 1));
    assign o_data             = r_res;

    always_comb begin
        fresh        = '0;
        fresh.node   = r_in.node_id;
        if (r_in.func == ptr_pkg::FUNC_UPDATE) begin
            fresh.addr_hi = r_in.addr_hi;
            fresh.addr_lo = r_in.addr_lo;
            fresh.mac     = r_in.mac;
            fresh.rank    = r_in.rank_in;
            fresh.metric  = r_in.metric_in;
        end else begin
            fresh.count   = 16'd1;
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_tab[i] = r_tab[i];
        end
        for (int i = 0; i < SLOTS - 1; i++) begin
            if (((i % 2) == 1) == r_pass[0] && OCC_W'(i + 1) < r_occ &&
                less(r_tab[i + 1], r_tab[i])) begin
                n_tab[i]     = r_tab[i + 1];
                n_tab[i + 1] = r_tab[i];
            end
        end
    end

    always_comb begin
        n_res              = '0;
        n_res.match_status = ptr_pkg::MATCH_ABSENT;
        n_res.dropped      = r_dropped;
        case (r_in.func)
            ptr_pkg::FUNC_CHECK: begin
                n_res.match_status = r_match;
            end
            ptr_pkg::FUNC_UPDATE: begin
                if (r_occ != '0) begin
                    n_res.best_addr_hi       = r_tab[0].addr_hi;
                    n_res.best_addr_lo       = r_tab[0].addr_lo;
                    n_res.best_mac           = r_tab[0].mac;
                    n_res.best_rank_plus_one = bump(r_tab[0].rank);
                    n_res.best_node          = r_tab[0].node;
                    n_res.metric_out         = r_tab[0].metric;
                end
            end
            ptr_pkg::FUNC_COUNT_METRIC: begin
                n_res.metric_out = r_metric;
            end
            default: begin
                if (r_occ != '0) n_res.best_node = r_tab[0].node;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_step) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_tab[i] <= n_tab[i];
            end
        end else if (i_cmd.apply) begin
            if (key_hit) begin
                unique case (r_in.func)
                    ptr_pkg::FUNC_UPDATE: begin
                        r_tab[r_idx[IDX_W-1:0]].addr_hi <= r_in.addr_hi;
                        r_tab[r_idx[IDX_W-1:0]].addr_lo <= r_in.addr_lo;
                        r_tab[r_idx[IDX_W-1:0]].mac     <= r_in.mac;
                        r_tab[r_idx[IDX_W-1:0]].rank    <= r_in.rank_in;
                        r_tab[r_idx[IDX_W-1:0]].metric  <= r_in.metric_in;
                    end
                    ptr_pkg::FUNC_COUNT_METRIC, ptr_pkg::FUNC_COUNT_ONLY: begin
                        r_tab[r_idx[IDX_W-1:0]].count <= bump(cur.count);
                    end
                    default: ;
                endcase
            end else if (r_in.func != ptr_pkg::FUNC_CHECK && !full) begin
                r_tab[r_occ[IDX_W-1:0]] <= fresh;
            end
        end else if (i_cmd.write_metric && r_kv) begin
            r_tab[r_idx[IDX_W-1:0]].metric <= sat_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.apply && !key_hit && r_in.func != ptr_pkg::FUNC_CHECK && !full) begin
            r_occ <= r_occ + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in      <= i_data;
            r_idx     <= '0;
            r_kv      <= 1'b0;
            r_dropped <= 1'b0;
            r_match   <= ptr_pkg::MATCH_ABSENT;
        end
        if (i_cmd.scan_step) begin
            if (key_hit) begin
                r_match <= (cur.rank == r_in.rank_in) ? ptr_pkg::MATCH_SAME
                                                      : ptr_pkg::MATCH_DIFF;
            end else begin
                r_idx <= r_idx + OCC_W'(1);
            end
        end
        if (i_cmd.apply) begin
            r_pass <= '0;
            r_dcnt <= '0;
            r_rem  <= '0;
            r_dvd  <= DW'(r_in.num_dio) << FRAC;
            if (key_hit) begin
                r_kv  <= 1'b1;
                r_cnt <= bump(cur.count);
            end else begin
                r_cnt <= 16'd1;
                if (r_in.func != ptr_pkg::FUNC_CHECK) begin
                    if (full) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_kv  <= 1'b1;
                        r_idx <= r_occ;
                    end
                end
            end
        end
        if (i_cmd.sort_step) begin
            r_pass <= r_pass + OCC_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? 16'(rem_sh - {1'b0, r_cnt}) : rem_sh[15:0];
            r_dvd  <= {r_dvd[DW-2:0], ge};
            r_dcnt <= r_dcnt + DC_W'(1);
        end
        if (i_cmd.write_metric) begin
            r_metric <= sat_m;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end
endmodule
`default_nettype wire

[verif/parent_table_ranker_tb.sv]
`timescale 1ns / 1ps
module parent_table_ranker_tb;

    localparam int SLOTS = 16;
    localparam int FRAC = 16;

    typedef struct {
        logic [15:0] node;
        logic [63:0] ahi;
        logic [63:0] alo;
        logic [47:0] mac;
        logic [15:0] rank;
        logic [31:0] metric;
        logic [15:0] count;
    } t_slot;

    class parent_scoreboard;
        t_slot              tab[SLOTS];
        int                 occ;
        ptr_pkg::t_out_item pending[$];
        int                 errors;

        function new();
            occ = 0;
            errors = 0;
        endfunction

        function int find_node(logic [15:0] id);
            for (int i = 0; i < occ; i++) if (tab[i].node == id) return i;
            return -1;
        endfunction

        function int append(logic [15:0] id);
            if (occ >= SLOTS) return -1;
            tab[occ] = '{id, 64'd0, 64'd0, 48'd0, 16'd0, 32'd0, 16'd0};
            occ++;
            return occ - 1;
        endfunction

        function void sort_table();
            t_slot cur;
            int j;
            for (int i = 1; i < occ; i++) begin
                cur = tab[i];
                j = i;
                while (j > 0 && (cur.metric < tab[j-1].metric ||
                       (cur.metric == tab[j-1].metric && cur.rank < tab[j-1].rank))) begin
                    tab[j] = tab[j-1];
                    j--;
                end
                tab[j] = cur;
            end
        endfunction

        function logic [15:0] bump(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        function void note_input(ptr_pkg::t_in_item it);
            ptr_pkg::t_out_item r;
            int k;
            logic [15:0] cnt;
            logic [63:0] q, sum;
            r = '0;
            r.match_status = ptr_pkg::MATCH_ABSENT;
            case (it.func)
                ptr_pkg::FUNC_CHECK: begin
                    for (int i = 0; i < occ; i++)
                        if (tab[i].ahi == it.addr_hi && tab[i].alo == it.addr_lo) begin
                            r.match_status = (tab[i].rank == it.rank_in) ?
                                             ptr_pkg::MATCH_SAME : ptr_pkg::MATCH_DIFF;
                            break;
                        end
                end
                ptr_pkg::FUNC_UPDATE: begin
                    k = find_node(it.node_id);
                    if (k < 0) begin
                        k = append(it.node_id);
                        if (k < 0) r.dropped = 1'b1;
                    end
                    if (k >= 0) begin
                        tab[k].metric = it.metric_in;
                        tab[k].rank = it.rank_in;
                        tab[k].mac = it.mac;
                        tab[k].ahi = it.addr_hi;
                        tab[k].alo = it.addr_lo;
                    end
                    sort_table();
                    if (occ > 0) begin
                        r.best_addr_hi = tab[0].ahi;
                        r.best_addr_lo = tab[0].alo;
                        r.best_mac = tab[0].mac;
                        r.best_rank_plus_one = bump(tab[0].rank);
                        r.best_node = tab[0].node;
                        r.metric_out = tab[0].metric;
                    end
                end
                ptr_pkg::FUNC_COUNT_METRIC: begin
                    k = find_node(it.node_id);
                    if (k >= 0) begin
                        tab[k].count = bump(tab[k].count);
                        cnt = tab[k].count;
                    end else begin
                        cnt = 16'd1;
                        k = append(it.node_id);
                        if (k < 0) r.dropped = 1'b1;
                        else tab[k].count = 16'd1;
                    end
                    q = ({48'd0, it.num_dio} << FRAC) / {48'd0, (cnt == 0 ? 16'd1 : cnt)};
                    sum = q + {32'd0, it.precount} + {32'd0, it.extra_cost};
                    r.metric_out = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
                    if (k >= 0) tab[k].metric = r.metric_out;
                end
                default: begin
                    k = find_node(it.node_id);
                    if (k >= 0) tab[k].count = bump(tab[k].count);
                    else begin
                        k = append(it.node_id);
                        if (k < 0) r.dropped = 1'b1;
                        else tab[k].count = 16'd1;
                    end
                    sort_table();
                    if (occ > 0) r.best_node = tab[0].node;
                end
            endcase
            pending = {pending, r};
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(ptr_pkg::t_out_item got);
            ptr_pkg::t_out_item w;
            if (pending.size() == 0) begin
                report("unexpected transaction", 64'(got.best_node), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (got.match_status !== w.match_status)
                report("match_status", 64'(got.match_status), 64'(w.match_status));
            if (got.dropped !== w.dropped)
                report("dropped", 64'(got.dropped), 64'(w.dropped));
            if (got.best_addr_hi !== w.best_addr_hi)
                report("best_addr_hi", got.best_addr_hi, w.best_addr_hi);
            if (got.best_addr_lo !== w.best_addr_lo)
                report("best_addr_lo", got.best_addr_lo, w.best_addr_lo);
            if (got.best_mac !== w.best_mac)
                report("best_mac", 64'(got.best_mac), 64'(w.best_mac));
            if (got.best_rank_plus_one !== w.best_rank_plus_one)
                report("best_rank_plus_one", 64'(got.best_rank_plus_one),
                       64'(w.best_rank_plus_one));
            if (got.best_node !== w.best_node)
                report("best_node", 64'(got.best_node), 64'(w.best_node));
            if (got.metric_out !== w.metric_out)
                report("metric_out", 64'(got.metric_out), 64'(w.metric_out));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    parent_scoreboard board;

    ptr_stream_if #(.T(ptr_pkg::t_in_item))  item_ch ();
    ptr_stream_if #(.T(ptr_pkg::t_out_item)) res_ch ();

    parent_table_ranker DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_ch.sink),
        .o_res  (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) board.note_input(item_ch.data);
            if (res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
        end
    end

    initial begin
        int g;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            g = gap_len();
            res_ch.ready = (g == 0);
            repeat (g) @(negedge i_clk);
            res_ch.ready = 1'b1;
            @(negedge i_clk);
        end
    end

    logic [15:0] node_pool[8];
    logic [63:0] ahi_pool[8];
    logic [63:0] alo_pool[8];

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] edge32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    task automatic send(ptr_pkg::t_in_item it);
        item_ch.data = it;
        item_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        repeat (gap_len()) @(negedge i_clk);
    endtask

    function automatic ptr_pkg::t_in_item rand_item(bit from_pool);
        ptr_pkg::t_in_item it;
        logic [2:0] p;
        p = 3'($urandom_range(0, 7));
        it.func = ptr_pkg::t_func'($urandom_range(0, 3));
        it.node_id = from_pool ? node_pool[p] : 16'($urandom());
        it.addr_hi = from_pool ? ahi_pool[p] : rnd64();
        it.addr_lo = from_pool ? alo_pool[p] : rnd64();
        it.mac = {$urandom(), 16'($urandom())};
        it.rank_in = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 7));
        it.metric_in = ($urandom_range(0, 3) == 0) ? edge32() : 32'($urandom_range(0, 15));
        it.precount = edge32();
        it.num_dio = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom());
        it.extra_cost = edge32();
        return it;
    endfunction

    initial begin
        ptr_pkg::t_in_item it;
        board = new();
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int i = 0; i < 8; i++) begin
            node_pool[i] = 16'($urandom());
            ahi_pool[i] = rnd64();
            alo_pool[i] = rnd64();
        end
        node_pool[0] = 16'h0000;
        node_pool[1] = 16'hFFFF;
        ahi_pool[1] = '1;
        alo_pool[1] = '1;
        ahi_pool[0] = '0;
        alo_pool[0] = '0;

        it = rand_item(1'b1);
        it.func = ptr_pkg::FUNC_CHECK;
        send(it);
        it.func = ptr_pkg::FUNC_UPDATE;
        it.rank_in = 16'hFFFF;
        send(it);
        it.func = ptr_pkg::FUNC_CHECK;
        send(it);
        it.rank_in = 16'd3;
        send(it);
        it.func = ptr_pkg::FUNC_COUNT_METRIC;
        it.node_id = 16'h1234;
        it.num_dio = 16'hFFFF;
        it.precount = 32'hFFFFFFFF;
        send(it);
        it.func = ptr_pkg::FUNC_COUNT_ONLY;
        it.node_id = 16'h4321;
        send(it);
        for (int i = 0; i < 16; i++) begin
            it = rand_item(1'b0);
            it.func = (i % 2) ? ptr_pkg::FUNC_UPDATE : ptr_pkg::FUNC_COUNT_METRIC;
            send(it);
        end
        for (int f = 1; f < 4; f++) begin
            it = rand_item(1'b0);
            it.func = ptr_pkg::t_func'(f);
            send(it);
        end

        for (int n = 0; n < 1350; n++) begin
            if (n % 150 == 0) begin
                item_ch.valid = 1'b0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            it = rand_item($urandom_range(0, 9) < 8);
            if (n >= 700 && $urandom_range(0, 3) == 0 && it.func != ptr_pkg::FUNC_UPDATE)
                it.num_dio = 16'hFFFF;
            send(it);
        end

        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/ptr_pkg.sv
design/ptr_stream_if.sv
design/ptr_ctrl.sv
design/ptr_dp.sv
design/parent_table_ranker.sv
verif/parent_table_ranker_tb.sv
